// ===== hw/rtl/altc_pkg.sv =====
// shared types, constants and character tests for the assembly line token classifier
`default_nettype none
package altc_pkg;

  // line geometry
  localparam int unsigned MAX_LINE_LEN = 1024;
  localparam int unsigned SPAN_START_W = 10;
  localparam int unsigned SPAN_LEN_W   = 11;
  localparam int unsigned LINE_POS_W   = $clog2(MAX_LINE_LEN + 1);
  localparam int unsigned CLASS_W      = 4;

  // result queue geometry
  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCOUNT_W = $clog2(QDEPTH + 1);

  // character codes
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;

  // token classes
  typedef enum logic [CLASS_W-1:0] {
    CL_INDENT    = 4'd0,
    CL_COMMENT   = 4'd1,
    CL_ALIAS     = 4'd2,
    CL_LABEL     = 4'd3,
    CL_DIRECTIVE = 4'd4,
    CL_INSTR     = 4'd5,
    CL_REGIDX    = 4'd6,
    CL_STR       = 4'd7,
    CL_CHAR      = 4'd8,
    CL_NUM       = 4'd9,
    CL_IMM       = 4'd10,
    CL_HEX       = 4'd11,
    CL_BIN       = 4'd12,
    CL_NONE      = 4'd15
  } tok_class_t;

  // one result beat
  typedef struct packed {
    logic [SPAN_START_W-1:0] span_start;
    logic [SPAN_LEN_W-1:0]   span_length;
    logic [CLASS_W-1:0]      token_class;
    logic                    run_last;
  } span_res_t;

  // results produced by one character, in order
  typedef struct packed {
    logic [1:0] cnt;
    span_res_t  first;
    span_res_t  second;
  } span_push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || c == 8'h5F;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/altc_in_if.sv =====
// character input channel
`default_nettype none
interface altc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink (input valid, input char_code, input line_end, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/altc_out_if.sv =====
// token span result channel
`default_nettype none
interface altc_out_if;
  logic                                valid;
  logic                                ready;
  logic [altc_pkg::SPAN_START_W-1:0]   span_start;
  logic [altc_pkg::SPAN_LEN_W-1:0]     span_length;
  logic [altc_pkg::CLASS_W-1:0]        token_class;
  logic                                run_last;

  modport source (output valid, output span_start, output span_length,
                  output token_class, output run_last, input ready);
  modport sink (input valid, input span_start, input span_length,
                input token_class, input run_last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/assembly_line_token_classifier.sv =====
// top level: assembly line token classifier
// path: an accepted character beat is held in the input register, then its spans pass through the result queue
// throughput: one character per cycle while the result queue has room for two beats; a character
//   that yields two spans gives two output beats, absorbed by a 4-entry result queue
// reset: synchronous active-low rst_n clears the token state and the queue;
//   no token is open and position is zero after reset and after each line end
`default_nettype none
module assembly_line_token_classifier (
  input  wire logic   clk,
  input  wire logic   rst_n,
  altc_in_if.sink     in_ch,
  altc_out_if.source  out_ch
);

  logic                 room;
  altc_pkg::span_push_t push;
  altc_pkg::span_res_t  res;

  // character register and class update
  altc_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_char  (in_ch.char_code),
    .in_last  (in_ch.line_end),
    .room     (room),
    .push     (push)
  );

  // result queue
  altc_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.span_start  = res.span_start;
  assign out_ch.span_length = res.span_length;
  assign out_ch.token_class = res.token_class;
  assign out_ch.run_last    = res.run_last;

endmodule
`default_nettype wire

// ===== hw/rtl/altc_core.sv =====
// input register and per-character token class update
`default_nettype none
module altc_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              in_char,
  input  wire logic                    in_last,
  input  wire logic                    room,
  output altc_pkg::span_push_t         push
);

  logic                                 hold_valid_r;
  logic [7:0]                           hold_char_r;
  logic                                 hold_last_r;
  logic                                 fire;

  altc_pkg::tok_class_t                 cls_r, cls_nxt, cls_mid;
  logic [altc_pkg::SPAN_START_W-1:0]    begin_r, begin_nxt, begin_mid;
  logic [altc_pkg::SPAN_LEN_W-1:0]      stop_r, stop_nxt, stop_mid, stop_adv;
  logic [altc_pkg::LINE_POS_W-1:0]      pos_r, pos_nxt, pos_inc;
  logic                                 comment_r, comment_nxt, comment_mid;

  logic                                 active;
  logic                                 restart;
  logic                                 wd;
  altc_pkg::tok_class_t                 fin;
  logic [altc_pkg::LINE_POS_W-1:0]      idx;
  logic                                 a_valid, b_valid;
  altc_pkg::span_res_t                  res_a, res_b;

  // one character is processed per cycle when the queue has room for two beats
  assign fire     = hold_valid_r && room;
  assign in_ready = !hold_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_char_r <= in_char;
      hold_last_r <= in_last;
    end
  end

  // class machine for the held character
  always_comb begin
    idx      = pos_r;
    pos_inc  = (pos_r < altc_pkg::LINE_POS_W'(altc_pkg::MAX_LINE_LEN)) ?
               pos_r + 1'b1 : pos_r;
    active   = !comment_r && (pos_r < altc_pkg::LINE_POS_W'(altc_pkg::MAX_LINE_LEN));
    wd       = altc_pkg::is_word(hold_char_r) || altc_pkg::is_digit(hold_char_r);
    cls_mid     = cls_r;
    begin_mid   = begin_r;
    stop_mid    = stop_r;
    stop_adv    = stop_r;
    comment_mid = comment_r;
    restart     = 1'b0;
    fin         = altc_pkg::CL_NONE;
    a_valid     = 1'b0;
    res_a       = '0;

    if (active) begin
      if (hold_char_r == altc_pkg::CH_SEMI) begin
        // comment opens; the token it interrupts keeps its own span
        a_valid           = (cls_r != altc_pkg::CL_NONE);
        res_a.span_start  = begin_r;
        res_a.span_length = stop_r - {1'b0, begin_r};
        res_a.token_class = cls_r;
        begin_mid   = idx[altc_pkg::SPAN_START_W-1:0];
        stop_mid    = idx + 1'b1;
        cls_mid     = altc_pkg::CL_COMMENT;
        comment_mid = 1'b1;
      end else begin
        case (cls_r)
          altc_pkg::CL_NONE: begin
            restart = 1'b1;
            if (altc_pkg::is_word(hold_char_r)) cls_mid = altc_pkg::CL_ALIAS;
            else if (altc_pkg::is_digit(hold_char_r)) cls_mid = altc_pkg::CL_NUM;
            else if (hold_char_r == altc_pkg::CH_SQUOTE) cls_mid = altc_pkg::CL_CHAR;
            else if (hold_char_r == altc_pkg::CH_DQUOTE) cls_mid = altc_pkg::CL_STR;
            else if (hold_char_r == altc_pkg::CH_HASH) cls_mid = altc_pkg::CL_IMM;
            else if (hold_char_r == altc_pkg::CH_DOLLAR) cls_mid = altc_pkg::CL_HEX;
            else if (hold_char_r == altc_pkg::CH_PCT) cls_mid = altc_pkg::CL_BIN;
            else if (altc_pkg::is_space(hold_char_r) && idx == '0)
              cls_mid = altc_pkg::CL_INDENT;
            else restart = 1'b0;
          end
          altc_pkg::CL_INDENT: begin
            restart = 1'b1;
            if (altc_pkg::is_word(hold_char_r)) cls_mid = altc_pkg::CL_INSTR;
            else if (hold_char_r == altc_pkg::CH_DOT) cls_mid = altc_pkg::CL_DIRECTIVE;
            else if (altc_pkg::is_space(hold_char_r)) restart = 1'b0;
            else cls_mid = altc_pkg::CL_NONE;
          end
          altc_pkg::CL_ALIAS: begin
            if (wd) begin
              stop_adv = stop_r + 1'b1;
            end else if (hold_char_r == altc_pkg::CH_COLON) begin
              cls_mid = altc_pkg::CL_LABEL;
            end else begin
              cls_mid = (hold_char_r == altc_pkg::CH_COMMA) ?
                        altc_pkg::CL_REGIDX : altc_pkg::CL_NONE;
              restart = 1'b1;
              fin     = altc_pkg::CL_ALIAS;
            end
          end
          altc_pkg::CL_LABEL: begin
            // the byte after the colon ends the label and may open its own span
            if (wd) cls_mid = altc_pkg::CL_INSTR;
            else if (hold_char_r == altc_pkg::CH_DOT) cls_mid = altc_pkg::CL_DIRECTIVE;
            else cls_mid = altc_pkg::CL_NONE;
            restart = (cls_mid != altc_pkg::CL_NONE);
            fin     = altc_pkg::CL_LABEL;
          end
          altc_pkg::CL_DIRECTIVE, altc_pkg::CL_INSTR, altc_pkg::CL_REGIDX: begin
            if ((cls_r == altc_pkg::CL_REGIDX) ? altc_pkg::is_word(hold_char_r) : wd) begin
              stop_adv = stop_r + 1'b1;
            end else begin
              cls_mid = altc_pkg::CL_NONE;
              restart = 1'b1;
              fin     = cls_r;
            end
          end
          altc_pkg::CL_STR, altc_pkg::CL_CHAR: begin
            stop_adv = stop_r + 1'b1;
            if (hold_char_r == ((cls_r == altc_pkg::CL_STR) ?
                                altc_pkg::CH_DQUOTE : altc_pkg::CH_SQUOTE)) begin
              cls_mid = altc_pkg::CL_NONE;
              restart = 1'b1;
              fin     = cls_r;
            end
          end
          altc_pkg::CL_NUM: begin
            if (altc_pkg::is_hex(hold_char_r)) begin
              stop_adv = stop_r + 1'b1;
            end else begin
              cls_mid = (hold_char_r == altc_pkg::CH_COMMA) ?
                        altc_pkg::CL_REGIDX : altc_pkg::CL_NONE;
              restart = 1'b1;
              fin     = altc_pkg::CL_NUM;
            end
          end
          altc_pkg::CL_IMM: begin
            if (altc_pkg::is_word(hold_char_r)) cls_mid = altc_pkg::CL_ALIAS;
            else if (altc_pkg::is_digit(hold_char_r)) cls_mid = altc_pkg::CL_NUM;
            else if (hold_char_r == altc_pkg::CH_DOLLAR) cls_mid = altc_pkg::CL_HEX;
            else if (hold_char_r == altc_pkg::CH_PCT) cls_mid = altc_pkg::CL_BIN;
            else cls_mid = altc_pkg::CL_NONE;
            restart = 1'b1;
            fin     = altc_pkg::CL_IMM;
          end
          altc_pkg::CL_HEX, altc_pkg::CL_BIN: begin
            if ((cls_r == altc_pkg::CL_HEX) ? altc_pkg::is_hex(hold_char_r) :
                (hold_char_r == altc_pkg::CH_ZERO || hold_char_r == altc_pkg::CH_ONE))
              cls_mid = altc_pkg::CL_NUM;
            else
              cls_mid = altc_pkg::CL_NONE;
            restart = 1'b1;
            fin     = cls_r;
          end
          default: begin
            cls_mid = altc_pkg::CL_NONE;
          end
        endcase

        a_valid           = (fin != altc_pkg::CL_NONE);
        res_a.span_start  = begin_r;
        res_a.span_length = stop_adv - {1'b0, begin_r};
        res_a.token_class = fin;
        stop_mid          = stop_adv;
        if (restart) begin
          begin_mid = idx[altc_pkg::SPAN_START_W-1:0];
          stop_mid  = idx + 1'b1;
        end
      end
    end

    // end of line flushes whatever is open
    b_valid           = hold_last_r && (cls_mid != altc_pkg::CL_NONE);
    res_b.span_start  = begin_mid;
    res_b.span_length = pos_inc - {1'b0, begin_mid};
    res_b.token_class = cls_mid;
    res_b.run_last    = 1'b1;
    res_a.run_last    = !b_valid;
  end

  // pack results in order
  always_comb begin
    push = '0;
    if (fire) begin
      if (a_valid) begin
        push.first  = res_a;
        push.second = res_b;
        push.cnt    = b_valid ? 2'd2 : 2'd1;
      end else if (b_valid) begin
        push.first = res_b;
        push.cnt   = 2'd1;
      end
    end
  end

  // next state
  always_comb begin
    cls_nxt     = cls_r;
    begin_nxt   = begin_r;
    stop_nxt    = stop_r;
    pos_nxt     = pos_r;
    comment_nxt = comment_r;
    if (fire) begin
      if (hold_last_r) begin
        cls_nxt     = altc_pkg::CL_NONE;
        begin_nxt   = '0;
        stop_nxt    = '0;
        pos_nxt     = '0;
        comment_nxt = 1'b0;
      end else begin
        cls_nxt     = cls_mid;
        begin_nxt   = begin_mid;
        stop_nxt    = stop_mid;
        pos_nxt     = pos_inc;
        comment_nxt = comment_mid;
      end
    end
  end

  // token state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r     <= altc_pkg::CL_NONE;
      begin_r   <= '0;
      stop_r    <= '0;
      pos_r     <= '0;
      comment_r <= 1'b0;
    end else begin
      cls_r     <= cls_nxt;
      begin_r   <= begin_nxt;
      stop_r    <= stop_nxt;
      pos_r     <= pos_nxt;
      comment_r <= comment_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/altc_out_fifo.sv =====
// small result queue taking up to two beats per cycle and giving one
`default_nettype none
module altc_out_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire altc_pkg::span_push_t push,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output altc_pkg::span_res_t       out_res
);

  altc_pkg::span_res_t                mem_r [altc_pkg::QDEPTH];
  logic [altc_pkg::QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [altc_pkg::QPTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [altc_pkg::QCOUNT_W-1:0]      count_r, count_nxt;
  logic [altc_pkg::QPTR_W-1:0]        wr_ptr_inc;
  logic                               pop;

  // room for a full two-beat push
  assign room      = (count_r <= altc_pkg::QCOUNT_W'(altc_pkg::QDEPTH - 2));
  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_inc = wr_ptr_r + 1'b1;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + altc_pkg::QPTR_W'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + altc_pkg::QCOUNT_W'(push.cnt) - altc_pkg::QCOUNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry writes
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_inc] <= push.second;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/altc_checker.sv =====
// port-level checks for the token classifier and their bind
`default_nettype none
module altc_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [altc_pkg::SPAN_START_W-1:0]  out_span_start,
  input wire logic [altc_pkg::SPAN_LEN_W-1:0]    out_span_length,
  input wire logic [altc_pkg::CLASS_W-1:0]       out_token_class,
  input wire logic                               out_run_last
);

  // a stalled span beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_span_start) &&
    $stable(out_span_length) && $stable(out_token_class) && $stable(out_run_last))
    else $error("span beat changed while stalled");

  // nothing comes out in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("span beat right after reset");

  // an empty output side never back-pressures the input
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending span");

  // a span never runs past the end of the longest line
  a_span_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_span_start} + out_span_length) <=
                  altc_pkg::SPAN_LEN_W'(altc_pkg::MAX_LINE_LEN))
    else $error("span beyond line end");

endmodule

bind assembly_line_token_classifier altc_checker u_altc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_span_start  (out_ch.span_start),
  .out_span_length (out_ch.span_length),
  .out_token_class (out_ch.token_class),
  .out_run_last    (out_ch.run_last)
);
`default_nettype wire

// ===== verif/assembly_line_token_classifier_test.sv =====
// testbench for the assembly line token classifier: random source lines, span prediction
`timescale 1ns / 1ps
module assembly_line_token_classifier_test;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned RANDOM_CHARS = 320;
  localparam int unsigned MAX_REPORTS = 10;

  localparam string LETTERS = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
  localparam string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCXYZ_0123456789";
  localparam string DIGITS = "0123456789";
  localparam string HEX_CHARS = "0123456789abcdefABCDEF";
  localparam string BIN_CHARS = "01";
  localparam string BLANKS = "  \t\t\v\f\r\n";
  localparam string ODD_CHARS = ":.'\",#$%;\r\n";

  // spans expected from the character stream, checked in arrival order
  class token_span_tracker;
    altc_pkg::tok_class_t cls;
    int unsigned tok_begin;
    int unsigned tok_stop;
    int unsigned line_pos;
    bit restart;
    bit in_comment;
    altc_pkg::span_res_t batch[$];
    altc_pkg::span_res_t awaited_spans[$];
    int unsigned bad_spans;

    function new();
      clear_line();
      bad_spans = 0;
    endfunction

    function void clear_line();
      cls = altc_pkg::CL_NONE;
      tok_begin = 0;
      tok_stop = 0;
      line_pos = 0;
      restart = 1'b0;
      in_comment = 1'b0;
    endfunction

    static function bit letter(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
    endfunction

    static function bit numeral(logic [7:0] c);
      return c >= altc_pkg::CH_ZERO && c <= 8'h39;
    endfunction

    static function bit hexdig(logic [7:0] c);
      return numeral(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
    endfunction

    static function bit blank(logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    static function int unsigned gap(int unsigned hi, int unsigned lo);
      return (hi >= lo) ? hi - lo : 0;
    endfunction

    function void add_span(int unsigned start, int unsigned len, altc_pkg::tok_class_t k);
      altc_pkg::span_res_t r;
      r.span_start = altc_pkg::SPAN_START_W'(start);
      r.span_length = altc_pkg::SPAN_LEN_W'(len);
      r.token_class = k;
      r.run_last = 1'b0;
      batch.push_back(r);
    endfunction

    // class machine for one byte; returns the class of a finished token
    function altc_pkg::tok_class_t step_class(logic [7:0] c, int unsigned idx);
      altc_pkg::tok_class_t cur;
      bit wd;
      cur = cls;
      wd = letter(c) || numeral(c);
      case (cur)
        altc_pkg::CL_NONE: begin
          restart = 1'b1;
          if (letter(c)) cls = altc_pkg::CL_ALIAS;
          else if (numeral(c)) cls = altc_pkg::CL_NUM;
          else if (c == altc_pkg::CH_SQUOTE) cls = altc_pkg::CL_CHAR;
          else if (c == altc_pkg::CH_DQUOTE) cls = altc_pkg::CL_STR;
          else if (c == altc_pkg::CH_HASH) cls = altc_pkg::CL_IMM;
          else if (c == altc_pkg::CH_DOLLAR) cls = altc_pkg::CL_HEX;
          else if (c == altc_pkg::CH_PCT) cls = altc_pkg::CL_BIN;
          else if (blank(c) && idx == 0) cls = altc_pkg::CL_INDENT;
          else restart = 1'b0;
          return altc_pkg::CL_NONE;
        end
        altc_pkg::CL_INDENT: begin
          restart = 1'b1;
          if (letter(c)) cls = altc_pkg::CL_INSTR;
          else if (c == altc_pkg::CH_DOT) cls = altc_pkg::CL_DIRECTIVE;
          else if (blank(c)) restart = 1'b0;
          else cls = altc_pkg::CL_NONE;
          return altc_pkg::CL_NONE;
        end
        altc_pkg::CL_ALIAS: begin
          if (wd) begin
            tok_stop++;
            restart = 1'b0;
            return altc_pkg::CL_NONE;
          end
          if (c == altc_pkg::CH_COLON) begin
            cls = altc_pkg::CL_LABEL;
            restart = 1'b0;
            return altc_pkg::CL_NONE;
          end
          cls = (c == altc_pkg::CH_COMMA) ? altc_pkg::CL_REGIDX : altc_pkg::CL_NONE;
          restart = 1'b1;
          return altc_pkg::CL_ALIAS;
        end
        altc_pkg::CL_LABEL: begin
          if (wd) cls = altc_pkg::CL_INSTR;
          else if (c == altc_pkg::CH_DOT) cls = altc_pkg::CL_DIRECTIVE;
          else cls = altc_pkg::CL_NONE;
          restart = (cls != altc_pkg::CL_NONE);
          return altc_pkg::CL_LABEL;
        end
        altc_pkg::CL_DIRECTIVE, altc_pkg::CL_INSTR, altc_pkg::CL_REGIDX: begin
          if ((cur == altc_pkg::CL_REGIDX) ? letter(c) : wd) begin
            tok_stop++;
            restart = 1'b0;
            return altc_pkg::CL_NONE;
          end
          cls = altc_pkg::CL_NONE;
          restart = 1'b1;
          return cur;
        end
        altc_pkg::CL_STR, altc_pkg::CL_CHAR: begin
          tok_stop++;
          if (c == ((cur == altc_pkg::CL_STR) ? altc_pkg::CH_DQUOTE : altc_pkg::CH_SQUOTE))
          begin
            cls = altc_pkg::CL_NONE;
            restart = 1'b1;
            return cur;
          end
          restart = 1'b0;
          return altc_pkg::CL_NONE;
        end
        altc_pkg::CL_NUM: begin
          if (hexdig(c)) begin
            tok_stop++;
            restart = 1'b0;
            return altc_pkg::CL_NONE;
          end
          cls = (c == altc_pkg::CH_COMMA) ? altc_pkg::CL_REGIDX : altc_pkg::CL_NONE;
          restart = 1'b1;
          return altc_pkg::CL_NUM;
        end
        altc_pkg::CL_IMM: begin
          if (letter(c)) cls = altc_pkg::CL_ALIAS;
          else if (numeral(c)) cls = altc_pkg::CL_NUM;
          else if (c == altc_pkg::CH_DOLLAR) cls = altc_pkg::CL_HEX;
          else if (c == altc_pkg::CH_PCT) cls = altc_pkg::CL_BIN;
          else cls = altc_pkg::CL_NONE;
          restart = 1'b1;
          return altc_pkg::CL_IMM;
        end
        altc_pkg::CL_HEX, altc_pkg::CL_BIN: begin
          if ((cur == altc_pkg::CL_HEX) ? hexdig(c) :
              (c == altc_pkg::CH_ZERO || c == altc_pkg::CH_ONE))
            cls = altc_pkg::CL_NUM;
          else
            cls = altc_pkg::CL_NONE;
          restart = 1'b1;
          return cur;
        end
        default: begin
          cls = altc_pkg::CL_NONE;
          restart = 1'b0;
          return altc_pkg::CL_NONE;
        end
      endcase
    endfunction

    // accepted character beat: work out the spans it causes
    function void take_char(logic [7:0] c, logic last);
      int unsigned idx;
      altc_pkg::tok_class_t done;
      altc_pkg::span_res_t r;
      idx = line_pos;
      batch.delete();
      if (line_pos < altc_pkg::MAX_LINE_LEN) line_pos++;
      if (!in_comment && idx < altc_pkg::MAX_LINE_LEN) begin
        if (c == altc_pkg::CH_SEMI) begin
          // the token a comment cuts off keeps its own span
          if (cls != altc_pkg::CL_NONE) add_span(tok_begin, gap(tok_stop, tok_begin), cls);
          tok_begin = idx;
          tok_stop = idx + 1;
          cls = altc_pkg::CL_COMMENT;
          in_comment = 1'b1;
        end else begin
          done = step_class(c, idx);
          if (done != altc_pkg::CL_NONE) add_span(tok_begin, gap(tok_stop, tok_begin), done);
          if (restart) begin
            tok_begin = idx;
            tok_stop = idx + 1;
          end
        end
      end
      if (last) begin
        if (cls != altc_pkg::CL_NONE) add_span(tok_begin, gap(line_pos, tok_begin), cls);
        clear_line();
      end
      if (batch.size() > 0) begin
        r = batch.pop_back();
        r.run_last = 1'b1;
        batch.push_back(r);
      end
      foreach (batch[i]) awaited_spans.push_back(batch[i]);
    endfunction

    // accepted span beat: compare with the oldest expected span
    function void match_span(altc_pkg::span_res_t got);
      altc_pkg::span_res_t want;
      if (awaited_spans.size() == 0) begin
        bad_spans++;
        if (bad_spans <= MAX_REPORTS)
          $display("unexpected span: start %0d len %0d class %0d last %0d",
                   got.span_start, got.span_length, got.token_class, got.run_last);
        return;
      end
      want = awaited_spans.pop_front();
      if (got.span_start !== want.span_start || got.span_length !== want.span_length ||
          got.token_class !== want.token_class || got.run_last !== want.run_last) begin
        bad_spans++;
        if (bad_spans <= MAX_REPORTS)
          $display({"span mismatch: expected start %0d len %0d class %0d last %0d,",
                    " got %0d %0d %0d %0d"},
                   want.span_start, want.span_length, want.token_class, want.run_last,
                   got.span_start, got.span_length, got.token_class, got.run_last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int unsigned quiet = 0;
  logic [7:0] line_bytes[$];
  token_span_tracker spans;

  string directed [6] = '{
    "\tmv r1,#$f;c",
    "x:.b \"s\" 'q'",
    "7:%1 $",
    " ;",
    "a:?b,\377",
    "#9 #a #%0 lb:x"
  };

  altc_in_if in_ch();
  altc_out_if out_ch();

  assembly_line_token_classifier uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [7:0] pick_from(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic void add_word();
    line_bytes.push_back(pick_from(LETTERS));
    repeat ($urandom_range(0, 5)) line_bytes.push_back(pick_from(WORD_CHARS));
  endfunction

  // one source line: mostly well-formed tokens, some noise lines
  function automatic void compose_line(input int unsigned min_len);
    line_bytes.delete();
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, min_len + 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: repeat ($urandom_range(1, 3)) line_bytes.push_back(pick_from(BLANKS));
      4, 5: begin
        add_word();
        line_bytes.push_back(altc_pkg::CH_COLON);
      end
      default: ;
    endcase
    while (line_bytes.size() < min_len) begin
      case ($urandom_range(0, 15))
        0, 1: add_word();
        2: begin
          line_bytes.push_back(altc_pkg::CH_DOT);
          add_word();
        end
        3: begin
          line_bytes.push_back(pick_from(DIGITS));
          repeat ($urandom_range(0, 3)) line_bytes.push_back(pick_from(HEX_CHARS));
        end
        4: begin
          line_bytes.push_back(altc_pkg::CH_HASH);
          case ($urandom_range(0, 3))
            0: add_word();
            1: line_bytes.push_back(pick_from(DIGITS));
            2: begin
              line_bytes.push_back(altc_pkg::CH_DOLLAR);
              line_bytes.push_back(pick_from(HEX_CHARS));
            end
            default: begin
              line_bytes.push_back(altc_pkg::CH_PCT);
              line_bytes.push_back(pick_from(BIN_CHARS));
            end
          endcase
        end
        5: begin
          line_bytes.push_back(altc_pkg::CH_DOLLAR);
          repeat ($urandom_range(1, 3)) line_bytes.push_back(pick_from(HEX_CHARS));
        end
        6: begin
          line_bytes.push_back(altc_pkg::CH_PCT);
          repeat ($urandom_range(1, 8)) line_bytes.push_back(pick_from(BIN_CHARS));
        end
        7: begin
          line_bytes.push_back(altc_pkg::CH_DQUOTE);
          repeat ($urandom_range(0, 5)) line_bytes.push_back(8'($urandom_range(32, 126)));
          if ($urandom_range(0, 9) < 9) line_bytes.push_back(altc_pkg::CH_DQUOTE);
        end
        8: begin
          line_bytes.push_back(altc_pkg::CH_SQUOTE);
          line_bytes.push_back(8'($urandom_range(32, 126)));
          line_bytes.push_back(altc_pkg::CH_SQUOTE);
        end
        9: line_bytes.push_back(altc_pkg::CH_COMMA);
        10, 11: repeat ($urandom_range(1, 3)) line_bytes.push_back(pick_from(BLANKS));
        12: begin
          line_bytes.push_back(altc_pkg::CH_SEMI);
          repeat ($urandom_range(0, 8)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        13: line_bytes.push_back(8'($urandom_range(0, 255)));
        14: begin
          // label followed directly by an instruction or directive
          add_word();
          line_bytes.push_back(altc_pkg::CH_COLON);
          if ($urandom_range(0, 1)) line_bytes.push_back(altc_pkg::CH_DOT);
          add_word();
        end
        default: line_bytes.push_back(pick_from(ODD_CHARS));
      endcase
    end
  endfunction

  // offer one character beat, with random gaps, until accepted
  task automatic send_char(input logic [7:0] c, input logic last);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.char_code <= c;
    in_ch.line_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    spans.take_char(c, last);
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_bytes[i]) send_char(line_bytes[i], i == line_bytes.size() - 1);
  endtask

  // result side: random stalls, and one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= calm || $urandom_range(0, 99) >= 36;
    end
  end

  // check every accepted span beat
  always @(posedge clk) begin : watch_spans
    altc_pkg::span_res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.span_start = out_ch.span_start;
      got.span_length = out_ch.span_length;
      got.token_class = out_ch.token_class;
      got.run_last = out_ch.run_last;
      spans.match_span(got);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int unsigned line_no;
    int unsigned random_chars;
    string s;
    spans = new();
    in_ch.valid = 1'b0;
    in_ch.char_code = 8'h00;
    in_ch.line_end = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed lines: every class, comment cut, label endings, stray bytes
    foreach (directed[k]) begin
      s = directed[k];
      line_bytes.delete();
      for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
      send_line();
    end

    // random lines, with one over-long line
    line_no = 0;
    random_chars = 0;
    while (random_chars < RANDOM_CHARS) begin
      calm = (line_no >= 10 && line_no < 18);
      if (line_no == 7) hold_req = 1'b1;
      if (line_no == 5) begin
        // token that runs past the line limit
        line_bytes.delete();
        repeat (1018) line_bytes.push_back(8'h20);
        s = "mov_abcdef";
        for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
        send_line();
      end else begin
        compose_line($urandom_range(1, 24));
        random_chars += line_bytes.size();
        send_line();
      end
      line_no++;
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // drain, then allow stray late beats to show up
    while (spans.awaited_spans.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (spans.awaited_spans.size() != 0)
      $display("%0d expected spans never arrived", spans.awaited_spans.size());
    if (spans.bad_spans == 0 && spans.awaited_spans.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/altc_pkg.sv
hw/rtl/altc_in_if.sv
hw/rtl/altc_out_if.sv
hw/rtl/altc_core.sv
hw/rtl/altc_out_fifo.sv
hw/rtl/assembly_line_token_classifier.sv
hw/rtl/altc_checker.sv
verif/assembly_line_token_classifier_test.sv
